### design/sorted_priority_table_macros.svh
// Assertion macros used by the sorted priority table sequencer.
`ifndef SORTED_PRIORITY_TABLE_MACROS_SVH
`define SORTED_PRIORITY_TABLE_MACROS_SVH

`ifndef ASSERT_OFF

`define SPT_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define SPT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SPT_ASSERT(lbl, clk, rst, prop, msg)

`define SPT_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

### design/spt_pkg.sv
// Types and constants shared by the sorted priority table modules.
package spt_pkg;

  localparam int ID_W   = 16;
  localparam int PRIO_W = 8;
  localparam int CNT_W  = 5;

  localparam logic [1:0] CMD_INSERT    = 2'd0;
  localparam logic [1:0] CMD_REM_HIGH  = 2'd1;
  localparam logic [1:0] CMD_REM_GIVEN = 2'd2;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_NOMATCH = 2'd2;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [ID_W-1:0]   entry_id;
    logic [PRIO_W-1:0] priority_req;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [CNT_W-1:0] removed_count;
    logic [CNT_W-1:0] occupancy;
  } rsp_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_LOOP,
    S_INS_PUT,
    S_HI_RD,
    S_HI_CAP,
    S_RM_RD,
    S_RM_LOOP,
    S_RM_FIN,
    S_RESP
  } state_t;

endpackage

### design/sorted_priority_table.sv
// Top level of the sorted priority table: sequencer, slot memory and response register.
//
// The table holds up to DEPTH (id, priority) entries in ascending priority order, equal
// priorities in arrival order. One request is taken at a time through the single read
// port of the slot memory, one slot per cycle: an insert scans the entries above the
// insert point, a remove-given scans the whole fill level, and a remove-highest reads the
// top entry and then scans the whole fill level for its priority. The response is
// held in an output register, so a new request can be taken while it waits.
module sorted_priority_table #(
  parameter int DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  spt_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output spt_pkg::rsp_t rsp
);
  import spt_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic          res_valid;
  logic          res_ready;
  rsp_t          res;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic [AW-1:0] mem_raddr;
  entry_t        mem_rdata;

  assign res_ready = !rsp_valid || rsp_ready;

  spt_seq #(
    .DEPTH(DEPTH),
    .AW   (AW),
    .CW   (CW)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res),
    .mem_we   (mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata)
  );

  spt_mem #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      rsp <= res;
    end
  end

endmodule

### design/spt_mem.sv
// Slot memory holding the table entries, one write and one registered read port.
module spt_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  spt_pkg::entry_t wdata,
  input  logic [AW-1:0]   raddr,
  output spt_pkg::entry_t rdata
);
  import spt_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/spt_seq.sv
// Command sequencer that scans, shifts and compacts the slot memory one slot per cycle.
module spt_seq #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int CW    = 5
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  spt_pkg::req_t   req,
  output logic            res_valid,
  input  logic            res_ready,
  output spt_pkg::rsp_t   res,
  output logic            mem_we,
  output logic [AW-1:0]   mem_waddr,
  output spt_pkg::entry_t mem_wdata,
  output logic [AW-1:0]   mem_raddr,
  input  spt_pkg::entry_t mem_rdata
);
  import spt_pkg::*;

  `include "sorted_priority_table_macros.svh"

  state_t            state, state_next;
  logic [CW-1:0]     fill;
  logic [CW-1:0]     wr_cnt;
  logic [CW-1:0]     rem;
  logic [AW-1:0]     cur;
  logic [PRIO_W-1:0] key;
  logic [ID_W-1:0]   new_id;
  logic [1:0]        status_r;

  logic          accept;
  logic          is_full;
  logic          is_empty;
  logic          slot_gt;
  logic          slot_eq;
  logic          rm_last;
  logic [AW-1:0] last_idx;

  assign accept   = req_valid && req_ready;
  assign is_full  = (fill == CW'(DEPTH));
  assign is_empty = (fill == '0);
  assign last_idx = AW'(fill - 1'b1);
  assign slot_gt  = (mem_rdata.prio > key);
  assign slot_eq  = (mem_rdata.prio == key);
  assign rm_last  = (cur == last_idx);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          unique case (req.cmd)
            CMD_INSERT: begin
              if (is_full) begin
                state_next = S_RESP;
              end else if (is_empty) begin
                state_next = S_INS_PUT;
              end else begin
                state_next = S_INS_RD;
              end
            end
            CMD_REM_HIGH:  state_next = is_empty ? S_RESP : S_HI_RD;
            CMD_REM_GIVEN: state_next = is_empty ? S_RESP : S_RM_RD;
            default:       state_next = S_RESP;
          endcase
        end
      end
      S_INS_RD: state_next = S_INS_LOOP;
      S_INS_LOOP: begin
        if (!slot_gt) begin
          state_next = S_RESP;
        end else if (cur == '0) begin
          state_next = S_INS_PUT;
        end
      end
      S_INS_PUT: state_next = S_RESP;
      S_HI_RD:   state_next = S_HI_CAP;
      S_HI_CAP:  state_next = S_RM_RD;
      S_RM_RD:   state_next = S_RM_LOOP;
      S_RM_LOOP: begin
        if (rm_last) begin
          state_next = S_RM_FIN;
        end
      end
      S_RM_FIN: state_next = S_RESP;
      S_RESP: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req_ready          = 1'b0;
    res_valid          = 1'b0;
    mem_we             = 1'b0;
    mem_waddr          = cur;
    mem_wdata          = mem_rdata;
    mem_raddr          = cur;
    res.status         = status_r;
    res.removed_count  = CNT_W'(rem);
    res.occupancy      = CNT_W'(fill);
    unique case (state)
      S_IDLE: req_ready = 1'b1;
      S_INS_LOOP: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(cur + 1'b1);
        mem_raddr = AW'(cur - 1'b1);
        if (!slot_gt) begin
          mem_wdata.id   = new_id;
          mem_wdata.prio = key;
        end
      end
      S_INS_PUT: begin
        mem_we         = 1'b1;
        mem_wdata.id   = new_id;
        mem_wdata.prio = key;
      end
      S_RM_LOOP: begin
        mem_we    = !slot_eq;
        mem_waddr = wr_cnt[AW-1:0];
        mem_raddr = AW'(cur + 1'b1);
      end
      S_RESP: res_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill  <= '0;
    end else begin
      state <= state_next;
      if ((state == S_INS_LOOP && !slot_gt) || state == S_INS_PUT) begin
        fill <= CW'(fill + 1'b1);
      end else if (state == S_RM_FIN) begin
        fill <= wr_cnt;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        key      <= req.priority_req;
        new_id   <= req.entry_id;
        rem      <= '0;
        wr_cnt   <= '0;
        status_r <= ST_DONE;
        cur      <= '0;
        if (accept) begin
          if (req.cmd == CMD_INSERT) begin
            if (is_full) begin
              status_r <= ST_FULL;
            end else if (!is_empty) begin
              cur <= last_idx;
            end
          end else if (req.cmd == CMD_REM_HIGH) begin
            cur <= last_idx;
            if (is_empty) begin
              status_r <= ST_NOMATCH;
            end
          end else if (req.cmd != CMD_REM_GIVEN || is_empty) begin
            status_r <= ST_NOMATCH;
          end
        end
      end
      S_INS_LOOP: begin
        if (slot_gt && cur != '0) begin
          cur <= AW'(cur - 1'b1);
        end
      end
      S_HI_CAP: begin
        key <= mem_rdata.prio;
        cur <= '0;
      end
      S_RM_LOOP: begin
        cur <= AW'(cur + 1'b1);
        if (slot_eq) begin
          rem <= CW'(rem + 1'b1);
        end else begin
          wr_cnt <= CW'(wr_cnt + 1'b1);
        end
      end
      S_RM_FIN: begin
        status_r <= (rem != '0) ? ST_DONE : ST_NOMATCH;
      end
      default: ;
    endcase
  end

  `SPT_ASSERT(a_fill_bound, clk, rst, fill <= CW'(DEPTH), "fill level exceeds table depth")
  `SPT_ASSERT(a_full_drop, clk, rst, (accept && req.cmd == CMD_INSERT && is_full) |=> (state == S_RESP && status_r == ST_FULL), "insert into full table not dropped")
  `SPT_ASSERT(a_fill_change, clk, rst, !$stable(fill) |-> ($past(state) == S_INS_LOOP || $past(state) == S_INS_PUT || $past(state) == S_RM_FIN), "fill level changed outside a commit step")
  `SPT_ASSERT(a_compact, clk, rst, (state == S_RM_LOOP) |-> ({1'b0, wr_cnt} + {1'b0, rem} == (CW + 1)'(cur)), "kept plus removed count out of step with scan index")
  `SPT_ASSERT(a_idle_no_write, clk, rst, (state == S_IDLE || state == S_RESP) |-> !mem_we, "slot memory written while no command is active")

endmodule
